FILE: design/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants of the source character tokenizer
// Character codes, token kinds, error codes, queue item formats and the
// small lookup functions used by the front classifier and the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

    // Fixed field widths of the token record
    localparam int KIND_W  = 5;
    localparam int VALUE_W = 64;
    localparam int OFF_W   = 20;
    localparam int LEN_W   = 7;
    localparam int LC_W    = 21;
    localparam int ERR_W   = 2;

    localparam logic [OFF_W-1:0] OFF_MAX = 20'hFFFFF;
    localparam logic [LC_W-1:0]  LC_MAX  = 21'h1FFFFF;

    // Keyword prefix: first six bytes of a name, first byte in the top bits
    localparam int KW_BYTES = 6;
    localparam int KW_BITS  = KW_BYTES * 8;

    // Queue depths (power of two)
    localparam int ITEM_QUEUE_DEPTH   = 4;
    localparam int RESULT_QUEUE_DEPTH = 4;

    // Character codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_EOF    = 5'd0;
    localparam logic [KIND_W-1:0] KIND_LET    = 5'd1;
    localparam logic [KIND_W-1:0] KIND_PRINT  = 5'd2;
    localparam logic [KIND_W-1:0] KIND_IF     = 5'd3;
    localparam logic [KIND_W-1:0] KIND_ELSE   = 5'd4;
    localparam logic [KIND_W-1:0] KIND_WHILE  = 5'd5;
    localparam logic [KIND_W-1:0] KIND_FN     = 5'd6;
    localparam logic [KIND_W-1:0] KIND_RETURN = 5'd7;
    localparam logic [KIND_W-1:0] KIND_NAME   = 5'd8;
    localparam logic [KIND_W-1:0] KIND_NUM    = 5'd9;
    localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd10;
    localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd11;
    localparam logic [KIND_W-1:0] KIND_STAR   = 5'd12;
    localparam logic [KIND_W-1:0] KIND_SLASH  = 5'd13;
    localparam logic [KIND_W-1:0] KIND_LPAR   = 5'd14;
    localparam logic [KIND_W-1:0] KIND_RPAR   = 5'd15;
    localparam logic [KIND_W-1:0] KIND_LBRC   = 5'd16;
    localparam logic [KIND_W-1:0] KIND_RBRC   = 5'd17;
    localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd18;
    localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd19;
    localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd20;
    localparam logic [KIND_W-1:0] KIND_EQEQ   = 5'd21;
    localparam logic [KIND_W-1:0] KIND_NEQ    = 5'd22;
    localparam logic [KIND_W-1:0] KIND_LT     = 5'd23;
    localparam logic [KIND_W-1:0] KIND_LE     = 5'd24;
    localparam logic [KIND_W-1:0] KIND_GT     = 5'd25;
    localparam logic [KIND_W-1:0] KIND_GE     = 5'd26;
    localparam logic [KIND_W-1:0] KIND_ANDAND = 5'd27;
    localparam logic [KIND_W-1:0] KIND_OROR   = 5'd28;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_CHAR = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TOO_LONG = 2'd2;

    // Character classes assigned by the front
    typedef enum logic [2:0] {
        CLS_SPACE = 3'd0,
        CLS_ALPHA = 3'd1,
        CLS_DIGIT = 3'd2,
        CLS_HOLD  = 3'd3,   // may start a two-character operator
        CLS_PUNCT = 3'd4,   // complete one-character token
        CLS_BAD   = 3'd5
    } char_class_t;

    // Scanner modes
    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_NAME    = 6'b000010,
        MODE_NUM     = 6'b000100,
        MODE_OP      = 6'b001000,
        MODE_COMMENT = 6'b010000,
        MODE_HALT    = 6'b100000
    } scan_mode_t;

    // Classified item from front to scanner
    typedef struct packed {
        logic                is_end;
        logic [7:0]          char_code;
        char_class_t         cls;
        logic [KIND_W-1:0]   punct_kind;
    } item_t;

    // Token record from scanner to output
    typedef struct packed {
        logic [KIND_W-1:0]   token_kind;
        logic [VALUE_W-1:0]  number_value;
        logic [OFF_W-1:0]    start_offset;
        logic [LEN_W-1:0]    name_length;
        logic [LC_W-1:0]     line_number;
        logic [LC_W-1:0]     column_number;
        logic [ERR_W-1:0]    error_code;
        logic                last_of_run;
    } result_t;

    // Kind of a held operator byte on its own; KIND_EOF when it may not stand alone
    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] p);
        logic [KIND_W-1:0] k;
        case (p)
            CH_EQ:    k = KIND_ASSIGN;
            CH_LT:    k = KIND_LT;
            CH_GT:    k = KIND_GT;
            CH_SLASH: k = KIND_SLASH;
            default:  k = KIND_EOF;
        endcase
        return k;
    endfunction

    // Two-character operator formed by held byte p and next byte c; KIND_EOF if none
    function automatic logic [KIND_W-1:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
        logic [KIND_W-1:0] k;
        k = KIND_EOF;
        if (c == CH_EQ) begin
            case (p)
                CH_EQ:   k = KIND_EQEQ;
                CH_BANG: k = KIND_NEQ;
                CH_LT:   k = KIND_LE;
                CH_GT:   k = KIND_GE;
                default: k = KIND_EOF;
            endcase
        end else if (c == CH_AMP && p == CH_AMP) begin
            k = KIND_ANDAND;
        end else if (c == CH_BAR && p == CH_BAR) begin
            k = KIND_OROR;
        end
        return k;
    endfunction

    // Keyword lookup on the stored prefix and the name length
    function automatic logic [KIND_W-1:0] keyword_kind(input logic [KW_BITS-1:0] p,
                                                       input logic [LEN_W-1:0] n);
        logic [KIND_W-1:0] k;
        k = KIND_NAME;
        if (n == 7'd3 && p[47:24] == "let") begin
            k = KIND_LET;
        end else if (n == 7'd5 && p[47:8] == "print") begin
            k = KIND_PRINT;
        end else if (n == 7'd2 && p[47:32] == "if") begin
            k = KIND_IF;
        end else if (n == 7'd4 && p[47:16] == "else") begin
            k = KIND_ELSE;
        end else if (n == 7'd5 && p[47:8] == "while") begin
            k = KIND_WHILE;
        end else if (n == 7'd2 && p[47:32] == "fn") begin
            k = KIND_FN;
        end else if (n == 7'd6 && p == "return") begin
            k = KIND_RETURN;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: design/stc_queue.sv
// ----------------------------------------------------------------------------
// stc_queue: short register queue with up to two pushes and one pop a cycle
// DEPTH must be a power of two, at least two. A second push in a cycle
// lands behind the first and is only given together with it.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push0,
    input  wire logic [WIDTH-1:0]             data0,
    input  wire logic                         push1,
    input  wire logic [WIDTH-1:0]             data1,
    input  wire logic                         pop,
    output logic      [WIDTH-1:0]             head,
    output logic      [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + PTR_W'(push0) + PTR_W'(push1);
    assign rd_ptr_next  = rd_ptr_reg + PTR_W'(pop);
    assign count_next   = count_reg + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots need no reset
    always_ff @(posedge clk) begin
        if (push0) begin
            slot_reg[wr_ptr_reg] <= data0;
        end
        if (push1) begin
            slot_reg[wr_ptr_plus1] <= data1;
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

FILE: design/stc_front.sv
// ----------------------------------------------------------------------------
// stc_front: input handshake and character classification
// Accept one item whenever the item queue has room, tag it with its
// character class and, for one-character tokens, the token kind.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_front (
    input  wire logic          src_valid,
    input  wire logic          req_type,
    input  wire logic [7:0]    char_code,
    input  wire logic          queue_full,
    output logic               src_stall,
    output logic               item_push,
    output stc_pkg::item_t     item
);

    import stc_pkg::*;

    char_class_t       cls;
    logic [KIND_W-1:0] punct_kind;

    always_comb begin
        punct_kind = KIND_EOF;
        case (char_code)
            CH_PLUS:  punct_kind = KIND_PLUS;
            CH_MINUS: punct_kind = KIND_MINUS;
            CH_STAR:  punct_kind = KIND_STAR;
            CH_LPAR:  punct_kind = KIND_LPAR;
            CH_RPAR:  punct_kind = KIND_RPAR;
            CH_LBRC:  punct_kind = KIND_LBRC;
            CH_RBRC:  punct_kind = KIND_RBRC;
            CH_SEMI:  punct_kind = KIND_SEMI;
            CH_COMMA: punct_kind = KIND_COMMA;
            default:  punct_kind = KIND_EOF;
        endcase
    end

    always_comb begin
        if (char_code inside {8'h20, [8'd9:8'd13]}) begin
            cls = CLS_SPACE;
        end else if (char_code inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F}) begin
            cls = CLS_ALPHA;
        end else if (char_code inside {[8'h30:8'h39]}) begin
            cls = CLS_DIGIT;
        end else if (char_code inside {CH_EQ, CH_BANG, CH_LT, CH_GT, CH_AMP, CH_BAR,
                                       CH_SLASH}) begin
            cls = CLS_HOLD;
        end else if (punct_kind != KIND_EOF) begin
            cls = CLS_PUNCT;
        end else begin
            cls = CLS_BAD;
        end
    end

    assign src_stall = queue_full;
    assign item_push = src_valid && !queue_full;

    always_comb begin
        item.is_end     = req_type;
        item.char_code  = char_code;
        item.cls        = cls;
        item.punct_kind = punct_kind;
    end

endmodule

`default_nettype wire

FILE: design/stc_scan.sv
// ----------------------------------------------------------------------------
// stc_scan: token scanner
// Take one classified item per cycle when the result queue has room for
// two records, advance the scan state and emit zero, one or two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_scan #(
    parameter int SOURCE_BYTES = 1048576,
    parameter int NAME_LIMIT   = 128
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    input  wire stc_pkg::item_t item,
    input  wire logic          res_room,
    output logic               item_take,
    output logic               push0,
    output stc_pkg::result_t   res0,
    output logic               push1,
    output stc_pkg::result_t   res1
);

    import stc_pkg::*;

    localparam int POS_W = $clog2(SOURCE_BYTES + 1);
    localparam int CNT_W = $clog2(NAME_LIMIT);

    scan_mode_t          mode_reg,      mode_next;
    logic [VALUE_W-1:0]  acc_reg,       acc_next;
    logic [CNT_W-1:0]    cnt_reg,       cnt_next;
    logic [KW_BITS-1:0]  prefix_reg,    prefix_next;
    logic [7:0]          pend_reg,      pend_next;
    logic [POS_W-1:0]    pos_reg,       pos_next;
    logic [LC_W-1:0]     line_reg,      line_next;
    logic [LC_W-1:0]     col_reg,       col_next;
    logic [POS_W-1:0]    tok_off_reg,   tok_off_next;
    logic [LC_W-1:0]     tok_line_reg,  tok_line_next;
    logic [LC_W-1:0]     tok_col_reg,   tok_col_next;

    logic                first_vld, second_vld;
    result_t             first, second;
    logic                go_idle;
    logic                adv;
    logic                pos_full;
    logic [7:0]          c;
    logic [KIND_W-1:0]   pair;
    logic [KIND_W-1:0]   held_kind;
    logic [LEN_W-1:0]    name_len;
    logic [KIND_W-1:0]   name_kind;
    logic [OFF_W-1:0]    tok_off_sat;
    logic [OFF_W-1:0]    pos_sat;

    function automatic logic [OFF_W-1:0] sat_off(input logic [POS_W-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        if (w > 32'(OFF_MAX)) begin
            return OFF_MAX;
        end
        return w[OFF_W-1:0];
    endfunction

    function automatic result_t make_res(input logic [KIND_W-1:0]  kind,
                                         input logic [VALUE_W-1:0] value,
                                         input logic [OFF_W-1:0]   off,
                                         input logic [LEN_W-1:0]   len,
                                         input logic [LC_W-1:0]    line,
                                         input logic [LC_W-1:0]    col,
                                         input logic [ERR_W-1:0]   err);
        result_t r;
        r.token_kind    = kind;
        r.number_value  = value;
        r.start_offset  = off;
        r.name_length   = len;
        r.line_number   = line;
        r.column_number = col;
        r.error_code    = err;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    assign item_take   = item_valid && res_room;
    assign c           = item.char_code;
    assign pos_full    = 32'(pos_reg) >= 32'(SOURCE_BYTES);
    assign pair        = pair_kind(pend_reg, c);
    assign held_kind   = single_kind(pend_reg);
    assign name_len    = LEN_W'(cnt_reg);
    assign name_kind   = keyword_kind(prefix_reg, name_len);
    assign tok_off_sat = sat_off(tok_off_reg);
    assign pos_sat     = sat_off(pos_reg);

    always_comb begin
        mode_next     = mode_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        prefix_next   = prefix_reg;
        pend_next     = pend_reg;
        tok_off_next  = tok_off_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        first_vld     = 1'b0;
        second_vld    = 1'b0;
        first         = '0;
        second        = '0;
        go_idle       = 1'b0;
        adv           = 1'b0;

        if (item_take && mode_reg != MODE_HALT) begin
            if (item.is_end) begin
                // Flush any open token, then end of file; a held byte that may not stand alone gives an error instead
                mode_next  = MODE_HALT;
                second_vld = 1'b1;
                second     = make_res(KIND_EOF, '0, pos_sat, '0, line_reg, col_reg, ERR_NONE);
                case (mode_reg)
                    MODE_NAME: begin
                        first_vld = 1'b1;
                        first     = make_res(name_kind, '0, tok_off_sat, name_len,
                                             tok_line_reg, tok_col_reg, ERR_NONE);
                    end
                    MODE_NUM: begin
                        first_vld = 1'b1;
                        first     = make_res(KIND_NUM, acc_reg, tok_off_sat, '0,
                                             tok_line_reg, tok_col_reg, ERR_NONE);
                    end
                    MODE_OP: begin
                        first_vld = 1'b1;
                        if (held_kind == KIND_EOF) begin
                            first      = make_res(KIND_EOF, '0, tok_off_sat, '0,
                                                  tok_line_reg, tok_col_reg, ERR_BAD_CHAR);
                            second_vld = 1'b0;
                        end else begin
                            first = make_res(held_kind, '0, tok_off_sat, '0,
                                             tok_line_reg, tok_col_reg, ERR_NONE);
                        end
                    end
                    default: ;
                endcase
            end else if (!pos_full) begin
                case (mode_reg)
                    MODE_NAME: begin
                        if (item.cls == CLS_ALPHA || item.cls == CLS_DIGIT) begin
                            if (32'(cnt_reg) + 32'd1 >= 32'(NAME_LIMIT)) begin
                                first_vld = 1'b1;
                                first     = make_res(KIND_EOF, '0, tok_off_sat, '0,
                                                     tok_line_reg, tok_col_reg, ERR_TOO_LONG);
                                mode_next = MODE_HALT;
                            end else begin
                                for (int i = 1; i < KW_BYTES; i++) begin
                                    if (32'(cnt_reg) == i) begin
                                        prefix_next[KW_BITS-1-8*i -: 8] = c;
                                    end
                                end
                                cnt_next = cnt_reg + CNT_W'(1);
                                adv      = 1'b1;
                            end
                        end else begin
                            first_vld = 1'b1;
                            first     = make_res(name_kind, '0, tok_off_sat, name_len,
                                                 tok_line_reg, tok_col_reg, ERR_NONE);
                            go_idle   = 1'b1;
                        end
                    end
                    MODE_NUM: begin
                        if (item.cls == CLS_DIGIT) begin
                            // v*10 + d as two shifted adds
                            acc_next = (acc_reg << 3) + (acc_reg << 1)
                                     + {{(VALUE_W-4){1'b0}}, c[3:0]};
                            adv      = 1'b1;
                        end else begin
                            first_vld = 1'b1;
                            first     = make_res(KIND_NUM, acc_reg, tok_off_sat, '0,
                                                 tok_line_reg, tok_col_reg, ERR_NONE);
                            go_idle   = 1'b1;
                        end
                    end
                    MODE_OP: begin
                        if (pair != KIND_EOF) begin
                            first_vld = 1'b1;
                            first     = make_res(pair, '0, tok_off_sat, '0,
                                                 tok_line_reg, tok_col_reg, ERR_NONE);
                            mode_next = MODE_IDLE;
                            adv       = 1'b1;
                        end else if (c == CH_SLASH && pend_reg == CH_SLASH) begin
                            mode_next = MODE_COMMENT;
                            adv       = 1'b1;
                        end else if (held_kind == KIND_EOF) begin
                            first_vld = 1'b1;
                            first     = make_res(KIND_EOF, '0, tok_off_sat, '0,
                                                 tok_line_reg, tok_col_reg, ERR_BAD_CHAR);
                            mode_next = MODE_HALT;
                        end else begin
                            first_vld = 1'b1;
                            first     = make_res(held_kind, '0, tok_off_sat, '0,
                                                 tok_line_reg, tok_col_reg, ERR_NONE);
                            go_idle   = 1'b1;
                        end
                    end
                    MODE_COMMENT: begin
                        if (c != CH_NL) begin
                            adv = 1'b1;
                        end else begin
                            go_idle = 1'b1;
                        end
                    end
                    default: begin
                        go_idle = 1'b1;
                    end
                endcase

                // Start of a new token from the idle state
                if (go_idle) begin
                    mode_next = MODE_IDLE;
                    if (item.cls != CLS_SPACE) begin
                        tok_off_next  = pos_reg;
                        tok_line_next = line_reg;
                        tok_col_next  = col_reg;
                    end
                    case (item.cls)
                        CLS_SPACE: begin
                            adv = 1'b1;
                        end
                        CLS_ALPHA: begin
                            prefix_next = {c, {(KW_BITS-8){1'b0}}};
                            cnt_next    = CNT_W'(1);
                            mode_next   = MODE_NAME;
                            adv         = 1'b1;
                        end
                        CLS_DIGIT: begin
                            acc_next  = {{(VALUE_W-4){1'b0}}, c[3:0]};
                            mode_next = MODE_NUM;
                            adv       = 1'b1;
                        end
                        CLS_HOLD: begin
                            pend_next = c;
                            mode_next = MODE_OP;
                            adv       = 1'b1;
                        end
                        CLS_PUNCT: begin
                            second_vld = 1'b1;
                            second     = make_res(item.punct_kind, '0, pos_sat, '0,
                                                  line_reg, col_reg, ERR_NONE);
                            adv        = 1'b1;
                        end
                        default: begin
                            second_vld = 1'b1;
                            second     = make_res(KIND_EOF, '0, pos_sat, '0,
                                                  line_reg, col_reg, ERR_BAD_CHAR);
                            mode_next  = MODE_HALT;
                        end
                    endcase
                end
            end
        end
    end

    // Position, line and column advance
    always_comb begin
        pos_next  = pos_reg;
        line_next = line_reg;
        col_next  = col_reg;
        if (adv) begin
            pos_next = pos_reg + POS_W'(1);
            if (c == CH_NL) begin
                if (line_reg != LC_MAX) begin
                    line_next = line_reg + LC_W'(1);
                end
                col_next = LC_W'(1);
            end else if (col_reg != LC_MAX) begin
                col_next = col_reg + LC_W'(1);
            end
        end
    end

    // Pack the records: the flushed token goes ahead of the new one
    always_comb begin
        push0 = first_vld || second_vld;
        push1 = first_vld && second_vld;
        res0  = first_vld ? first : second;
        res1  = second;
        res0.last_of_run = !push1;
        res1.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg     <= MODE_IDLE;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            prefix_reg   <= '0;
            pend_reg     <= '0;
            pos_reg      <= '0;
            line_reg     <= LC_W'(1);
            col_reg      <= LC_W'(1);
            tok_off_reg  <= '0;
            tok_line_reg <= LC_W'(1);
            tok_col_reg  <= LC_W'(1);
        end else begin
            mode_reg     <= mode_next;
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            prefix_reg   <= prefix_next;
            pend_reg     <= pend_next;
            pos_reg      <= pos_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            tok_off_reg  <= tok_off_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/source_char_tokenizer_core.sv
// ----------------------------------------------------------------------------
// source_char_tokenizer_core: streaming source tokenizer
// Path: an item transfer is registered in the item queue, then the scanner
//   writes the item's first token into the result queue, which offers it on
//   tok_valid.
// Throughput: one item per cycle, taken by the scanner update;
//   an item is taken only while the result queue has room for two tokens.
// Reset: rst_n clears all scan state and both queues at once; no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module source_char_tokenizer_core #(
    parameter int SOURCE_BYTES = 1048576,   // 256 .. 1048576
    parameter int NAME_LIMIT   = 128        // 8 .. 128
) (
    input  wire logic          clk,
    input  wire logic          rst_n,

    // Source channel
    input  wire logic          src_valid,
    output logic               src_stall,
    input  wire logic          req_type,
    input  wire logic [7:0]    char_code,

    // Token channel
    output logic               tok_valid,
    input  wire logic          tok_stall,
    output logic [4:0]         token_kind,
    output logic [63:0]        number_value,
    output logic [19:0]        start_offset,
    output logic [6:0]         name_length,
    output logic [20:0]        line_number,
    output logic [20:0]        column_number,
    output logic [1:0]         error_code,
    output logic               last_of_run
);

    import stc_pkg::*;

    localparam int ITEM_CNT_W = $clog2(ITEM_QUEUE_DEPTH + 1);
    localparam int RES_CNT_W  = $clog2(RESULT_QUEUE_DEPTH + 1);

    // Front to item queue
    item_t                  front_item;
    logic                   item_push;
    logic                   item_full;
    logic [ITEM_CNT_W-1:0]  item_count;

    // Item queue to scanner
    logic [$bits(item_t)-1:0] item_head_bits;
    item_t                  item_head;
    logic                   item_valid;
    logic                   item_take;

    // Scanner to result queue
    logic                   res_push0;
    logic                   res_push1;
    result_t                res0;
    result_t                res1;
    logic                   res_room;
    logic [RES_CNT_W-1:0]   res_count;
    logic [$bits(result_t)-1:0] res_head_bits;
    result_t                res_head;
    logic                   res_pop;

    // ------------------------------------------------------------------
    // Front: accept the source transfer and classify the character
    // ------------------------------------------------------------------
    assign item_full = 32'(item_count) == ITEM_QUEUE_DEPTH;

    stc_front u_front (
        .src_valid  (src_valid),
        .req_type   (req_type),
        .char_code  (char_code),
        .queue_full (item_full),
        .src_stall  (src_stall),
        .item_push  (item_push),
        .item       (front_item)
    );

    // ------------------------------------------------------------------
    // Item queue: lets the front keep taking characters while the
    // scanner waits on the token side
    // ------------------------------------------------------------------
    stc_queue #(
        .WIDTH ($bits(item_t)),
        .DEPTH (ITEM_QUEUE_DEPTH)
    ) u_item_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push0 (item_push),
        .data0 (front_item),
        .push1 (1'b0),
        .data1 ('0),
        .pop   (item_take),
        .head  (item_head_bits),
        .count (item_count)
    );

    assign item_head  = item_t'(item_head_bits);
    assign item_valid = item_count != '0;

    // ------------------------------------------------------------------
    // Back: scanner, one item per cycle, up to two tokens per item.
    // Hold the item until the result queue can take two tokens.
    // ------------------------------------------------------------------
    assign res_room = 32'(res_count) + 32'd2 <= RESULT_QUEUE_DEPTH;

    stc_scan #(
        .SOURCE_BYTES (SOURCE_BYTES),
        .NAME_LIMIT   (NAME_LIMIT)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item_head),
        .res_room   (res_room),
        .item_take  (item_take),
        .push0      (res_push0),
        .res0       (res0),
        .push1      (res_push1),
        .res1       (res1)
    );

    // ------------------------------------------------------------------
    // Result queue: registered token output, drained one per transfer
    // ------------------------------------------------------------------
    stc_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RESULT_QUEUE_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push0 (res_push0),
        .data0 (res0),
        .push1 (res_push1),
        .data1 (res1),
        .pop   (res_pop),
        .head  (res_head_bits),
        .count (res_count)
    );

    assign res_head  = result_t'(res_head_bits);
    assign tok_valid = res_count != '0;
    assign res_pop   = tok_valid && !tok_stall;

    assign token_kind    = res_head.token_kind;
    assign number_value  = res_head.number_value;
    assign start_offset  = res_head.start_offset;
    assign name_length   = res_head.name_length;
    assign line_number   = res_head.line_number;
    assign column_number = res_head.column_number;
    assign error_code    = res_head.error_code;
    assign last_of_run   = res_head.last_of_run;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Tokens enter the result queue only for an item taken that cycle
    a_push_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        res_push0 |-> item_take)
        else $error("token pushed without an item taken");

    // A two-token item marks only its second token as last
    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_push1 |-> (!res0.last_of_run && res1.last_of_run))
        else $error("last_of_run misplaced in a token pair");

    // The result queue never overfills
    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(res_count) <= RESULT_QUEUE_DEPTH)
        else $error("result queue overflow");

    // End of file and errors are the final token: nothing follows them
    a_final_token: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && !tok_stall && token_kind == KIND_EOF) |=> !tok_valid)
        else $error("token offered after end of file or error");

endmodule

`default_nettype wire
